// ===== src/bole_pkg.sv =====
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 4;
  localparam int CNT_W_OUT = 4;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_READ      = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic [POS_W-1:0]         found_position;
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W_OUT-1:0]     entry_count;
    logic                     last;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_READ   = 2'd2
  } state_t;

endpackage

// ===== src/bole_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors and compares against a key.
module bole_cell #(
  parameter int CAPACITY = 8,
  parameter int INDEX    = 0
) (
  input  logic                              clk,
  input  bole_pkg::cell_op_t                op,
  input  logic [$clog2(CAPACITY)-1:0]       idx,
  input  logic signed [bole_pkg::WORD_W-1:0] load_value,
  input  logic signed [bole_pkg::WORD_W-1:0] left_value,
  input  logic signed [bole_pkg::WORD_W-1:0] right_value,
  output logic signed [bole_pkg::WORD_W-1:0] value,
  output logic                              match
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic signed [bole_pkg::WORD_W-1:0] value_r;
  logic signed [bole_pkg::WORD_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    unique case (op)
      bole_pkg::CELL_INSERT: begin
        if (MY_IDX == idx) begin
          value_nxt = load_value;
        end else if (MY_IDX > idx) begin
          value_nxt = left_value;
        end
      end
      bole_pkg::CELL_DELETE: begin
        if (MY_IDX >= idx) begin
          value_nxt = right_value;
        end
      end
      bole_pkg::CELL_ROTATE: value_nxt = right_value;
      default:               value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = (value_r == load_value);

endmodule

// ===== src/bounded_ordered_list_engine_unit.sv =====
// Top level of the bounded ordered list engine: control, count and the row of cells.
//
// A command word is taken on in_data at a rising edge where start is high and busy is
// low. Results leave on out_data, each valid for exactly one cycle while out_valid is
// high; the receiver cannot hold them off.
// Inserts and deletes shift every later entry together through the row of cells,
// so the result appears in the cycle after the command and busy stays low, letting
// a new command enter every cycle.
// A search compares all entries in the accepting cycle, registers the hit vector and
// encodes the highest hit in the next one, with busy high while it encodes.
// A read-out rotates the whole row once around, showing cell 0 at each step; the first
// count steps give one result each, the last one marked.
// Reading an empty list gives a single failing result in the next cycle.
// After reset the list is empty and no result is pending; entries are not cleared,
// since only slots below the count are ever read.
module bounded_ordered_list_engine_unit #(
  parameter int CAPACITY = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bole_pkg::in_t   in_data,
  output logic            out_valid,
  output bole_pkg::out_t  out_data
);

  localparam int IW     = $clog2(CAPACITY);
  localparam int CW_RAW = $clog2(CAPACITY + 1);
  localparam int CNT_W  = (CW_RAW > bole_pkg::POS_W) ? CW_RAW : bole_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
  localparam logic [IW-1:0]    LAST_ROT = IW'(CAPACITY - 1);

  bole_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IW-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic                out_valid_r, out_valid_nxt;
  bole_pkg::out_t      out_data_r, out_data_nxt;

  bole_pkg::cell_op_t  cell_op;
  logic [IW-1:0]       cell_idx;
  logic signed [bole_pkg::WORD_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] live;

  logic             accept;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] pos_idx;
  logic [CNT_W-1:0] ins_idx;
  logic [CNT_W-1:0] del_idx;
  logic             ins_ok;
  logic             del_ok;
  logic [CNT_W-1:0] hit;
  logic [CNT_W-1:0] rd_ext;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [bole_pkg::WORD_W-1:0] left_in;
      logic signed [bole_pkg::WORD_W-1:0] right_in;
      if (gi == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_mid
        assign left_in = cell_value[gi-1];
      end
      // The last cell wraps to the first so that a read-out rotates the list.
      if (gi == CAPACITY - 1) begin : g_wrap
        assign right_in = cell_value[0];
      end else begin : g_next
        assign right_in = cell_value[gi+1];
      end

      bole_cell #(
        .CAPACITY (CAPACITY),
        .INDEX    (gi)
      ) u_cell (
        .clk         (clk),
        .op          (cell_op),
        .idx         (cell_idx),
        .load_value  (in_data.value),
        .left_value  (left_in),
        .right_value (right_in),
        .value       (cell_value[gi]),
        .match       (cell_match[gi])
      );

      assign live[gi] = (CNT_W'(gi) < count_r);
    end
  endgenerate

  assign busy   = (state_r != bole_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Position decode; a position of zero is caught separately.
  assign pos_ext = CNT_W'(in_data.position);
  assign pos_idx = pos_ext - CNT_W'(1);
  assign rd_ext  = CNT_W'(rd_cnt_r);

  always_comb begin
    case (in_data.cmd)
      bole_pkg::CMD_INS_FRONT: ins_idx = '0;
      bole_pkg::CMD_INS_END:   ins_idx = count_r;
      default:                 ins_idx = pos_idx;
    endcase
    case (in_data.cmd)
      bole_pkg::CMD_DEL_FRONT: del_idx = '0;
      bole_pkg::CMD_DEL_END:   del_idx = count_r - CNT_W'(1);
      default:                 del_idx = pos_idx;
    endcase
    ins_ok = (count_r < CAP_C) && (ins_idx <= count_r) &&
             !((in_data.cmd == bole_pkg::CMD_INS_POS) && (in_data.position == '0));
    del_ok = (count_r != '0) && (del_idx < count_r) &&
             !((in_data.cmd == bole_pkg::CMD_DEL_POS) && (in_data.position == '0));
  end

  // The highest matching slot wins.
  always_comb begin
    hit = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_r[i]) begin
        hit = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bole_pkg::ST_IDLE: begin
        if (accept && (in_data.cmd == bole_pkg::CMD_SEARCH)) begin
          state_nxt = bole_pkg::ST_SEARCH;
        end else if (accept && (in_data.cmd == bole_pkg::CMD_READ) && (count_r != '0)) begin
          state_nxt = bole_pkg::ST_READ;
        end
      end
      bole_pkg::ST_SEARCH: state_nxt = bole_pkg::ST_IDLE;
      bole_pkg::ST_READ: begin
        if (rd_cnt_r == LAST_ROT) begin
          state_nxt = bole_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bole_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cell_op       = bole_pkg::CELL_HOLD;
    cell_idx      = '0;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    match_nxt     = match_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    out_data_nxt.ok             = 1'b0;
    out_data_nxt.found_position = '0;
    out_data_nxt.read_value     = '0;
    out_data_nxt.last           = 1'b1;

    unique case (state_r)
      bole_pkg::ST_IDLE: begin
        rd_cnt_nxt = '0;
        if (accept) begin
          case (in_data.cmd) inside
            bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_END, bole_pkg::CMD_INS_POS: begin
              out_valid_nxt   = 1'b1;
              out_data_nxt.ok = ins_ok;
              if (ins_ok) begin
                cell_op   = bole_pkg::CELL_INSERT;
                cell_idx  = ins_idx[IW-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bole_pkg::CMD_DEL_FRONT, bole_pkg::CMD_DEL_END, bole_pkg::CMD_DEL_POS: begin
              out_valid_nxt   = 1'b1;
              out_data_nxt.ok = del_ok;
              if (del_ok) begin
                cell_op   = bole_pkg::CELL_DELETE;
                cell_idx  = del_idx[IW-1:0];
                count_nxt = count_r - CNT_W'(1);
              end
            end
            bole_pkg::CMD_SEARCH: begin
              match_nxt = cell_match & live;
            end
            default: begin
              // Read-out of an empty list answers at once with a failing word.
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      bole_pkg::ST_SEARCH: begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.ok             = (hit != '0);
        out_data_nxt.found_position = hit[bole_pkg::POS_W-1:0];
      end
      bole_pkg::ST_READ: begin
        cell_op    = bole_pkg::CELL_ROTATE;
        rd_cnt_nxt = (rd_cnt_r == LAST_ROT) ? '0 : rd_cnt_r + IW'(1);
        if (rd_ext < count_r) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok         = 1'b1;
          out_data_nxt.read_value = cell_value[0];
          out_data_nxt.last       = (rd_ext == count_r - CNT_W'(1));
        end
      end
      default: begin
        cell_op = bole_pkg::CELL_HOLD;
      end
    endcase

    out_data_nxt.entry_count = count_nxt[bole_pkg::CNT_W_OUT-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::ST_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
